[hdl/mcbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcbf_pkg
// Types and codes shared by the multi-channel bounded FIFO unit: request and
// result payloads, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package mcbf_pkg;

  // fixed field widths of the request and result payloads
  localparam int CH_FIELD_W    = 3;
  localparam int DATA_FIELD_W  = 32;
  localparam int LIMIT_FIELD_W = 5;

  // request operations
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_SEND  = 2'd2,
    OP_RECV  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_CHANNEL  = 2'd1,
    ST_WOULD_BLOCK = 2'd2,
    ST_NO_FREE     = 2'd3
  } status_t;

  // request payload
  typedef struct packed {
    op_t                      operation;
    logic [CH_FIELD_W-1:0]    channel;
    logic [DATA_FIELD_W-1:0]  send_data;
    logic [LIMIT_FIELD_W-1:0] open_limit;
  } in_item_t;

  // result payload
  typedef struct packed {
    status_t                 status;
    logic [CH_FIELD_W-1:0]   channel_out;
    logic [DATA_FIELD_W-1:0] recv_data;
  } out_item_t;

  // request controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_EMIT
  } state_t;

endpackage : mcbf_pkg
`default_nettype wire

[hdl/mcbf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcbf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module mcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mcbf_ram
`default_nettype wire

[hdl/multi_channel_bounded_fifo_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_bounded_fifo_unit
// Set of bounded FIFO channels sharing one word store. Requests open, close,
// send to or receive from a channel; each request returns one status result.
// ----------------------------------------------------------------------------
// Sequence: the metadata read is issued with the transfer, then
// read-modify-write with queue access (S_META), then result load (S_EMIT).
// A new request is taken only in S_IDLE, after the result load; a stalled
// result holds the controller until the result register frees up.
// Reset: all channels closed; the metadata and word memories are not cleared
// and need no clearing pass, the unit takes requests right after reset.

module multi_channel_bounded_fifo_unit
  import mcbf_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_DEPTH    = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int HD_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int META_W  = 2 * CNT_W + HD_W;
  localparam int Q_DEPTH = NUM_CHANNELS * MAX_DEPTH;
  localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CHX_W   = CH_W + CH_FIELD_W;
  localparam int DX_W    = DATA_WIDTH + DATA_FIELD_W;
  localparam int LX_W    = CNT_W + LIMIT_FIELD_W;

  // controller and request registers
  state_t                  state_r, state_nxt;
  in_item_t                req_r;
  logic [NUM_CHANNELS-1:0] open_r, open_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [CH_FIELD_W-1:0]   res_ch_r, res_ch_nxt;
  logic                    res_recv_r, res_recv_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic in_xfer;
  logic out_free;

  // metadata memory ports
  logic              meta_we;
  logic [CH_W-1:0]   meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [CH_W-1:0]   meta_raddr;
  logic [META_W-1:0] meta_rdata;

  // word store ports
  logic                  q_we;
  logic                  q_re;
  logic [QA_W-1:0]       q_waddr;
  logic [QA_W-1:0]       q_raddr;
  logic [DATA_WIDTH-1:0] q_wdata;
  logic [DATA_WIDTH-1:0] q_rdata;

  // decoded request and metadata
  logic [CHX_W-1:0] in_ch_x;
  logic [CHX_W-1:0] req_ch_x;
  logic [CH_W-1:0]  req_ch;
  logic             req_ch_in_range;
  logic             chan_live;
  logic [CNT_W-1:0] m_limit;
  logic [HD_W-1:0]  m_head;
  logic [CNT_W-1:0] m_count;

  // derived values
  logic             free_found;
  logic [CH_W-1:0]  free_idx;
  logic [CHX_W-1:0] free_idx_x;
  logic [HD_W:0]    tail_sum;
  logic [HD_W:0]    tail_wrap;
  logic [HD_W:0]    head_inc;
  logic [HD_W-1:0]  head_nxt;
  logic [QA_W-1:0]  q_base;
  logic [LX_W-1:0]  lim_x;
  logic [CNT_W-1:0] lim_sat;
  logic [DX_W-1:0]  send_x;
  logic [DX_W-1:0]  recv_x;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // request field decode
  assign in_ch_x         = CHX_W'(in_data.channel);
  assign meta_raddr      = in_ch_x[CH_W-1:0];
  assign req_ch_x        = CHX_W'(req_r.channel);
  assign req_ch          = req_ch_x[CH_W-1:0];
  assign req_ch_in_range = req_ch_x < CHX_W'(NUM_CHANNELS);
  assign chan_live       = req_ch_in_range && open_r[req_ch];

  // metadata word layout: limit, head, count
  assign m_limit = meta_rdata[META_W-1 -: CNT_W];
  assign m_head  = meta_rdata[CNT_W +: HD_W];
  assign m_count = meta_rdata[CNT_W-1:0];

  // lowest closed channel
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end
  assign free_idx_x = CHX_W'(free_idx);

  // ring positions: tail for send, next head for receive
  assign tail_sum  = (HD_W + 1)'(m_head) + (HD_W + 1)'(m_count);
  assign tail_wrap = (tail_sum >= (HD_W + 1)'(MAX_DEPTH)) ?
                     tail_sum - (HD_W + 1)'(MAX_DEPTH) : tail_sum;
  assign head_inc  = (HD_W + 1)'(m_head) + (HD_W + 1)'(1);
  assign head_nxt  = (head_inc == (HD_W + 1)'(MAX_DEPTH)) ? '0 : head_inc[HD_W-1:0];

  // word store addressing: channel row plus ring index
  assign q_base  = QA_W'(req_ch) * QA_W'(MAX_DEPTH);
  assign q_waddr = q_base + QA_W'(tail_wrap[HD_W-1:0]);
  assign q_raddr = q_base + QA_W'(m_head);

  // limit saturation and data width adaption
  assign lim_x   = LX_W'(req_r.open_limit);
  assign lim_sat = (lim_x > LX_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : lim_x[CNT_W-1:0];
  assign send_x  = DX_W'(req_r.send_data);
  assign q_wdata = send_x[DATA_WIDTH-1:0];
  assign recv_x  = DX_W'(q_rdata);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // controller outputs: handshake, memory accesses, result
  always_comb begin
    in_stall       = (state_r != S_IDLE);
    meta_we        = 1'b0;
    meta_waddr     = req_ch;
    meta_wdata     = '0;
    q_we           = 1'b0;
    q_re           = 1'b0;
    open_nxt       = open_r;
    res_status_nxt = res_status_r;
    res_ch_nxt     = res_ch_r;
    res_recv_nxt   = res_recv_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    case (state_r)
      S_IDLE: begin
      end
      S_META: begin
        res_status_nxt = ST_OK;
        res_ch_nxt     = '0;
        res_recv_nxt   = 1'b0;
        if (req_r.operation == OP_OPEN) begin
          // take the lowest closed channel, empty ring
          if (free_found) begin
            open_nxt[free_idx] = 1'b1;
            meta_we            = 1'b1;
            meta_waddr         = free_idx;
            meta_wdata         = {lim_sat, {HD_W{1'b0}}, {CNT_W{1'b0}}};
            res_ch_nxt         = free_idx_x[CH_FIELD_W-1:0];
          end else begin
            res_status_nxt = ST_NO_FREE;
          end
        end else if (!chan_live) begin
          res_status_nxt = ST_NO_CHANNEL;
        end else begin
          case (req_r.operation)
            OP_CLOSE: begin
              open_nxt[req_ch] = 1'b0;
            end
            OP_SEND: begin
              // append at the tail unless full
              if (m_count >= m_limit) begin
                res_status_nxt = ST_WOULD_BLOCK;
              end else begin
                q_we       = 1'b1;
                meta_we    = 1'b1;
                meta_wdata = {m_limit, m_head, m_count + CNT_W'(1)};
              end
            end
            OP_RECV: begin
              // pop the head unless empty
              if (m_count == '0) begin
                res_status_nxt = ST_WOULD_BLOCK;
              end else begin
                q_re         = 1'b1;
                res_recv_nxt = 1'b1;
                meta_we      = 1'b1;
                meta_wdata   = {m_limit, head_nxt, m_count - CNT_W'(1)};
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        // load the result register once it is free
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.channel_out = res_ch_r;
          out_data_nxt.recv_data   = res_recv_r ? recv_x[DATA_FIELD_W-1:0] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    res_status_r <= res_status_nxt;
    res_ch_r     <= res_ch_nxt;
    res_recv_r   <= res_recv_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-channel metadata: limit, head, count
  mcbf_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_CHANNELS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (in_xfer),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // shared word store, one ring of MAX_DEPTH words per channel
  mcbf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (Q_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

endmodule : multi_channel_bounded_fifo_unit
`default_nettype wire
